// ===== hw/rtl/piecewise_linear_correction_lookup_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the piecewise-linear correction lookup
// Shared property forms; each use names its label, antecedent and consequent.
// ---------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_CORRECTION_LOOKUP_DEFINES_SVH
`define PIECEWISE_LINEAR_CORRECTION_LOOKUP_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent
`define PLCL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent
`define PLCL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/plcl_pkg.sv =====
// ---------------------------------------------------------------------------
// plcl_pkg
// Types and fixed constants shared by the correction lookup and its divider.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package plcl_pkg;

    // Fixed field widths
    localparam int MOM_W  = 16;
    localparam int CORR_W = 16;
    localparam int DIV_W  = 16;          // quotient bits
    localparam int PROD_W = 2 * DIV_W;   // dividend bits

    // Command codes
    typedef enum logic [1:0] {
        CMD_EVAL  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_COUNT = 2'd2
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_INTERP = 2'd0,
        STAT_LOW    = 2'd1,
        STAT_HIGH   = 2'd2,
        STAT_NONE   = 2'd3
    } t_status;

    // Evaluation sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_SCAN,
        S_MUL,
        S_DIVW,
        S_DONE
    } t_state;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] num;
        logic [DIV_W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
    } t_div_rsp;

endpackage

// ===== hw/rtl/plcl_div.sv =====
// ---------------------------------------------------------------------------
// plcl_div
// Restoring unsigned divider, one quotient bit per cycle. The dividend's
// upper half must be below the divisor so the quotient fits DIV_W bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module plcl_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  plcl_pkg::t_div_req  i_req,
    output plcl_pkg::t_div_rsp  o_rsp
);
    import plcl_pkg::*;

    localparam int STEP_W = $clog2(DIV_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_quo;    // dividend low bits shift out, quotient in

    logic [DIV_W:0]    rem_sh;
    logic [DIV_W:0]    rem_sub;
    logic              q_bit;

    // One trial subtraction
    always_comb begin
        rem_sh  = {r_rem, r_quo[DIV_W-1]};
        rem_sub = rem_sh - {1'b0, i_req.den};
        q_bit   = (rem_sh >= {1'b0, i_req.den});
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(DIV_W - 1);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num[PROD_W-1:DIV_W];
            r_quo <= i_req.num[DIV_W-1:0];
        end else if (r_busy) begin
            r_rem <= q_bit ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], q_bit};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

// ===== hw/rtl/piecewise_linear_correction_lookup.sv =====
// Piecewise-linear correction lookup. Keeps a breakpoint table per species in
// one synchronous memory (momentum and correction side by side) and a point
// count per species in flip-flops, cleared by reset. Write and set-count
// items give no result. An evaluate item gives one result: an unknown
// species or an empty table, a clamp below the first point or at or above
// the last point, or an interpolation through a segment. Evaluation time is
// set by the segment search, which reads one breakpoint per cycle through
// the memory's single read port, and by the 16-step divider. Input stalls
// while an evaluation is in progress; one finished result may wait in the
// output register while the next item is taken.
// ---------------------------------------------------------------------------
// piecewise_linear_correction_lookup
// Breakpoint tables with linear interpolation between neighboring points.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "piecewise_linear_correction_lookup_defines.svh"

module piecewise_linear_correction_lookup #(
    parameter int MAX_POINTS  = 32,
    parameter int NUM_SPECIES = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input items
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_cmd,
    input  logic [2:0]         i_species,
    input  logic [4:0]         i_point_index,
    input  logic [15:0]        i_momentum,
    input  logic signed [15:0] i_corr_in,
    input  logic [7:0]         i_point_count,
    // result items
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_corr_out,
    output logic [1:0]         o_status
);
    import plcl_pkg::*;

    localparam int DEPTH  = NUM_SPECIES * MAX_POINTS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int SP_W   = (NUM_SPECIES > 1) ? $clog2(NUM_SPECIES) : 1;
    localparam int ENT_W  = MOM_W + CORR_W;

    // Breakpoint memory and per-species counts
    logic [ENT_W-1:0]  r_bp_mem [DEPTH];
    logic [ENT_W-1:0]  r_rd_data;
    logic [CNT_W-1:0]  r_count [NUM_SPECIES];

    // Sequencer and evaluation context
    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_base;
    logic [ADDR_W-1:0] r_addr;       // address of the entry in r_rd_data during the search
    logic [CNT_W-1:0]  r_n;
    logic [MOM_W-1:0]  r_p;
    logic [MOM_W-1:0]  r_prev_m;
    logic [CORR_W-1:0] r_prev_c;
    logic [MOM_W-1:0]  r_dp;
    logic [DIV_W-1:0]  r_dc_mag;
    logic              r_neg;
    logic [MOM_W-1:0]  r_den;
    logic [CORR_W-1:0] r_res_corr;
    t_status           r_res_stat;

    // Output register
    logic              r_out_valid;
    logic [CORR_W-1:0] r_corr_out;
    logic [1:0]        r_status;

    logic              in_acc;
    logic              sp_ok;
    logic              idx_ok;
    logic [CNT_W-1:0]  sel_n;
    logic [CNT_W-1:0]  clamp_n;
    logic [ADDR_W-1:0] in_base;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              out_load;
    logic              out_free;
    logic [MOM_W-1:0]  cur_m;
    logic [CORR_W-1:0] cur_c;
    logic              found;
    logic [CORR_W:0]   dc;
    logic [CORR_W:0]   q_signed;
    logic [CORR_W:0]   fin_sum;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    // Input side is open only while idle
    assign o_in_stall = (r_state != S_IDLE);

    // Input decode
    always_comb begin
        in_acc  = i_in_valid && !o_in_stall;
        sp_ok   = int'(i_species) < NUM_SPECIES;
        idx_ok  = int'(i_point_index) < MAX_POINTS;
        sel_n   = sp_ok ? r_count[i_species[SP_W-1:0]] : '0;
        clamp_n = (int'(i_point_count) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
                                                     : CNT_W'(i_point_count);
        in_base = ADDR_W'(int'(i_species) * MAX_POINTS);
        wr_addr = ADDR_W'(int'(i_species) * MAX_POINTS + int'(i_point_index));
        wr_en   = in_acc && (i_cmd == CMD_WRITE) && sp_ok && idx_ok;
    end

    // Current entry and segment test
    always_comb begin
        cur_m    = r_rd_data[ENT_W-1:CORR_W];
        cur_c    = r_rd_data[CORR_W-1:0];
        found    = (r_prev_m <= r_p) && (r_p < cur_m);
        dc       = {cur_c[CORR_W-1], cur_c} - {r_prev_c[CORR_W-1], r_prev_c};
        q_signed = r_neg ? -{1'b0, div_rsp.quo} : {1'b0, div_rsp.quo};
        fin_sum  = {r_prev_c[CORR_W-1], r_prev_c} + q_signed;
        out_free = !r_out_valid || !i_out_stall;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_cmd == CMD_EVAL) begin
                    n_state = (sp_ok && sel_n != '0) ? S_FIRST : S_DONE;
                end
            end
            S_FIRST: begin
                n_state = (r_p < cur_m) ? S_DONE : S_LAST;
            end
            S_LAST: begin
                n_state = (r_p >= cur_m) ? S_DONE : S_SCAN;
            end
            S_SCAN: begin
                if (found) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_DIVW;
            end
            S_DIVW: begin
                if (div_rsp.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: read address, divider start, output load
    always_comb begin
        rd_addr       = r_addr + 1'b1;
        div_req.start = 1'b0;
        div_req.num   = PROD_W'(r_dc_mag) * PROD_W'(r_dp);
        div_req.den   = r_den;
        out_load      = 1'b0;
        unique case (r_state)
            S_IDLE:  rd_addr = in_base;
            S_FIRST: rd_addr = r_base + ADDR_W'(r_n) - 1'b1;
            S_LAST:  rd_addr = r_base + 1'b1;
            S_SCAN:  rd_addr = r_addr + 1'b1;
            S_MUL:   div_req.start = 1'b1;
            S_DIVW:  rd_addr = r_addr;
            S_DONE:  out_load = out_free;
            default: rd_addr = r_addr;
        endcase
    end

    // Breakpoint memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_bp_mem[wr_addr] <= {i_momentum, i_corr_in};
        end
        r_rd_data <= r_bp_mem[rd_addr];
    end

    // Point counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SPECIES; s++) begin
                r_count[s] <= '0;
            end
        end else if (in_acc && i_cmd == CMD_COUNT && sp_ok) begin
            r_count[i_species[SP_W-1:0]] <= clamp_n;
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Evaluation datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_base     <= in_base;
                r_addr     <= in_base;
                r_n        <= sel_n;
                r_p        <= i_momentum;
                r_res_corr <= '0;
                r_res_stat <= STAT_NONE;
            end
            S_FIRST: begin
                r_prev_m   <= cur_m;
                r_prev_c   <= cur_c;
                r_res_corr <= cur_c;
                r_res_stat <= STAT_LOW;
            end
            S_LAST: begin
                r_addr     <= r_base + 1'b1;
                r_res_corr <= cur_c;
                r_res_stat <= STAT_HIGH;
            end
            S_SCAN: begin
                if (found) begin
                    r_dp     <= r_p - r_prev_m;
                    r_den    <= cur_m - r_prev_m;
                    r_neg    <= dc[CORR_W];
                    r_dc_mag <= dc[CORR_W] ? DIV_W'(-dc) : DIV_W'(dc);
                end else begin
                    r_prev_m <= cur_m;
                    r_prev_c <= cur_c;
                    r_addr   <= r_addr + 1'b1;
                end
            end
            S_DIVW: begin
                if (div_rsp.done) begin
                    r_res_corr <= fin_sum[CORR_W-1:0];
                    r_res_stat <= STAT_INTERP;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_corr_out <= r_res_corr;
            r_status   <= r_res_stat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_corr_out  = r_corr_out;
    assign o_status    = r_status;

    // Interpolation divider
    plcl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Checks
    `PLCL_ASSERT_NOW(a_div_done_in_wait, div_rsp.done, r_state == S_DIVW, "divider done outside wait")
    `PLCL_ASSERT_NEXT(a_load_from_done, !o_out_valid || !i_out_stall, o_out_valid == $past(out_load), "output load mismatch")
    `PLCL_ASSERT_NEXT(a_no_result_cmds, in_acc && i_cmd != CMD_EVAL, r_state == S_IDLE, "non-evaluate item left idle")
    `PLCL_ASSERT_NOW(a_scan_bounded, r_state == S_SCAN, r_addr < r_base + ADDR_W'(r_n), "segment search past last point")

endmodule
